/* rtl/ris_pkg.sv */
// Shared types and opcode constants for the routine instruction sequencer.
`default_nettype none

package ris_pkg;

  localparam logic [3:0] OP_HALT      = 4'd0;
  localparam logic [3:0] OP_WAIT      = 4'd1;
  localparam logic [3:0] OP_MOVE      = 4'd2;
  localparam logic [3:0] OP_DIG       = 4'd3;
  localparam logic [3:0] OP_PLANT     = 4'd4;
  localparam logic [3:0] OP_SUMMON    = 4'd5;
  localparam logic [3:0] OP_SCYTHE    = 4'd6;
  localparam logic [3:0] OP_MINE      = 4'd7;
  localparam logic [3:0] OP_JUMP      = 4'd8;
  localparam logic [3:0] OP_JUMPIF    = 4'd9;
  localparam logic [3:0] OP_JUMPIFNOT = 4'd10;
  localparam logic [3:0] OP_CALL      = 4'd11;
  localparam logic [3:0] OP_RETURN    = 4'd12;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_STEP = 1'b1;

  // One program store entry.
  typedef struct packed {
    logic [3:0] op;
    logic [7:0] ticks;
    logic [1:0] dir;
    logic [7:0] threshold;
    logic [7:0] target;
    logic [2:0] cond;
  } instr_t;

  // One result transaction.
  typedef struct packed {
    logic       halt;
    logic       want_move;
    logic [1:0] move_rel_dir;
    logic [1:0] move_facing;
    logic       is_strafe;
    logic       want_dig;
    logic       want_plant;
    logic       want_summon;
    logic [7:0] summon_index;
    logic       want_scythe;
    logic       want_mine;
  } result_t;

endpackage

`default_nettype wire

/* rtl/ris_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module ris_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/routine_instruction_sequencer_core.sv */
// Top level of the routine instruction sequencer: program memory, return stack and tick logic.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------------
//   cfg     | in        | cfg_valid / cfg_ready | cfg_data: program_length
//   in      | in        | in_valid  / in_ready  | action, load_* fields, facing, stimuli_*
//   out     | out       | out_valid / out_ready | halt, want_* flags, move and summon fields
//
// A transaction is accepted into the execute slot; in the accept cycle the program memory
// and the return stack memory are read at the current program counter and stack top, and
// the instruction then executes from the slot once its result can go to the output register.
// The next transaction is accepted as soon as the execute slot is free, also while a
// result still waits in the output register; the execute slot stalls only when the
// output register is full and not being taken. Reset is synchronous and clears the
// program counter, wait count, stack depth, length and all valid flags; neither memory
// is cleared, so reset needs no clearing pass.
`default_nettype none

module routine_instruction_sequencer_core
  import ris_pkg::*;
#(
  parameter int PROGRAM_DEPTH = 256,
  parameter int STACK_DEPTH   = 8,
  parameter int NUM_STIMULI   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [7:0]  load_index,
  input  wire logic [3:0]  load_opcode,
  input  wire logic [7:0]  load_ticks,
  input  wire logic [1:0]  load_dir,
  input  wire logic [7:0]  load_threshold,
  input  wire logic [7:0]  load_target,
  input  wire logic [2:0]  load_cond,
  input  wire logic [1:0]  facing,
  input  wire logic [63:0] stimuli_packed,
  input  wire logic        stimuli_present,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             halt,
  output logic             want_move,
  output logic [1:0]       move_rel_dir,
  output logic [1:0]       move_facing,
  output logic             is_strafe,
  output logic             want_dig,
  output logic             want_plant,
  output logic             want_summon,
  output logic [7:0]       summon_index,
  output logic             want_scythe,
  output logic             want_mine
);

  // Program memory address width.
  localparam int AW    = $clog2(PROGRAM_DEPTH);
  // The program counter holds any 8-bit jump target and any value up to the store depth.
  localparam int PC_W  = ($clog2(PROGRAM_DEPTH + 1) > 8) ? $clog2(PROGRAM_DEPTH + 1) : 8;
  localparam int LEN_W = (PC_W > 9) ? PC_W : 9;
  localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW    = $clog2(STACK_DEPTH + 1);
  localparam int IW    = $bits(instr_t);

  // Configuration and architectural registers.
  logic [8:0]      program_length;
  logic [PC_W-1:0] program_counter, program_counter_next;
  logic [7:0]      wait_remaining, wait_remaining_next;
  logic [DW-1:0]   stack_depth, stack_depth_next;

  // Execute slot: holds a transaction while the memories answer.
  logic            s1_valid;
  logic            s1_step;
  logic [1:0]      s1_facing;
  logic [63:0]     s1_stim;

  // Output register.
  result_t         out_res;
  result_t         res;

  logic            in_fire;
  logic            commit;
  instr_t          ins;
  logic [IW-1:0]   prog_rd_data;
  logic [PC_W-1:0] stack_rd_data;
  logic            load_in_range;
  logic [AW-1:0]   prog_wr_addr;
  logic [DW-1:0]   stack_top;
  logic            stack_we;
  logic [PC_W-1:0] pc_plus1;
  logic [LEN_W-1:0] len_ext, len_eff, pc_ext;
  logic            at_end;
  logic [7:0]      stim_byte;
  logic [31:0]     load_index_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid;
  assign in_fire   = in_valid && in_ready;
  assign commit    = s1_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      program_length <= cfg_data;
    end
  end

  // Loads write the store directly in the accept cycle; the store is also read at the
  // program counter in every accept cycle, and a load leaves that read unused.
  assign load_index_ext = 32'(load_index);
  assign load_in_range  = load_index_ext < 32'(PROGRAM_DEPTH);
  assign prog_wr_addr   = load_index_ext[AW-1:0];

  ris_ram #(
    .WIDTH (IW),
    .DEPTH (PROGRAM_DEPTH)
  ) u_program_ram (
    .clk     (clk),
    .wr_en   (in_fire && (action == ACTION_LOAD) && load_in_range),
    .wr_addr (prog_wr_addr),
    .wr_data ({load_opcode, load_ticks, load_dir, load_threshold, load_target, load_cond}),
    .rd_en   (in_fire),
    .rd_addr (program_counter[AW-1:0]),
    .rd_data (prog_rd_data)
  );

  // The stack is read at its top on every accept so that a return finds its entry
  // waiting; pushes are written in the execute cycle at the first free entry.
  assign stack_top = stack_depth - 1'b1;

  ris_ram #(
    .WIDTH (PC_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stack_we),
    .wr_addr (stack_depth[SA_W-1:0]),
    .wr_data (pc_plus1),
    .rd_en   (in_fire),
    .rd_addr (stack_top[SA_W-1:0]),
    .rd_data (stack_rd_data)
  );

  assign ins = instr_t'(prog_rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_step   <= (action == ACTION_STEP);
      s1_facing <= facing;
      s1_stim   <= stimuli_present ? stimuli_packed : 64'd0;
    end
  end

  // End-of-routine check against the length clamped to the store depth.
  assign len_ext  = LEN_W'(program_length);
  assign len_eff  = (len_ext > LEN_W'(PROGRAM_DEPTH)) ? LEN_W'(PROGRAM_DEPTH) : len_ext;
  assign pc_ext   = LEN_W'(program_counter);
  assign at_end   = (len_eff == '0) || (pc_ext >= len_eff);
  assign pc_plus1 = program_counter + 1'b1;

  // Stimulus bytes beyond the configured count read as zero.
  assign stim_byte = (32'(ins.cond) < 32'(NUM_STIMULI)) ? s1_stim[8*ins.cond +: 8] : 8'd0;

  always_comb begin
    res                  = '0;
    program_counter_next = program_counter;
    wait_remaining_next  = wait_remaining;
    stack_depth_next     = stack_depth;
    stack_we             = 1'b0;
    if (s1_step) begin
      if (at_end) begin
        res.halt = 1'b1;
      end else if (wait_remaining != 8'd0) begin
        wait_remaining_next = wait_remaining - 1'b1;
      end else begin
        case (ins.op)
          OP_HALT: begin
            res.halt = 1'b1;
          end
          OP_WAIT: begin
            wait_remaining_next  = (ins.ticks != 8'd0) ? ins.ticks - 1'b1 : 8'd0;
            program_counter_next = pc_plus1;
          end
          OP_MOVE: begin
            res.want_move        = 1'b1;
            res.move_rel_dir     = ins.dir;
            res.move_facing      = s1_facing;
            res.is_strafe        = (ins.threshold != 8'd0);
            program_counter_next = pc_plus1;
          end
          OP_DIG: begin
            res.want_dig         = 1'b1;
            program_counter_next = pc_plus1;
          end
          OP_PLANT: begin
            res.want_plant       = 1'b1;
            program_counter_next = pc_plus1;
          end
          OP_SUMMON: begin
            res.want_summon      = 1'b1;
            res.summon_index     = ins.target;
            program_counter_next = pc_plus1;
          end
          OP_SCYTHE: begin
            res.want_scythe      = 1'b1;
            program_counter_next = pc_plus1;
          end
          OP_MINE: begin
            res.want_mine        = 1'b1;
            program_counter_next = pc_plus1;
          end
          OP_JUMP: begin
            program_counter_next = PC_W'(ins.target);
          end
          OP_JUMPIF: begin
            program_counter_next = (stim_byte > ins.threshold) ? PC_W'(ins.target) : pc_plus1;
          end
          OP_JUMPIFNOT: begin
            program_counter_next = (stim_byte <= ins.threshold) ? PC_W'(ins.target) : pc_plus1;
          end
          OP_CALL: begin
            if (stack_depth >= DW'(STACK_DEPTH)) begin
              res.halt = 1'b1;
            end else begin
              stack_we             = commit;
              stack_depth_next     = stack_depth + 1'b1;
              program_counter_next = PC_W'(ins.target);
            end
          end
          OP_RETURN: begin
            if (stack_depth == '0) begin
              res.halt = 1'b1;
            end else begin
              stack_depth_next     = stack_top;
              program_counter_next = stack_rd_data;
            end
          end
          default: begin
            res.halt = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_counter <= '0;
      wait_remaining  <= '0;
      stack_depth     <= '0;
    end else if (commit) begin
      program_counter <= program_counter_next;
      wait_remaining  <= wait_remaining_next;
      stack_depth     <= stack_depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res <= res;
    end
  end

  assign halt         = out_res.halt;
  assign want_move    = out_res.want_move;
  assign move_rel_dir = out_res.move_rel_dir;
  assign move_facing  = out_res.move_facing;
  assign is_strafe    = out_res.is_strafe;
  assign want_dig     = out_res.want_dig;
  assign want_plant   = out_res.want_plant;
  assign want_summon  = out_res.want_summon;
  assign summon_index = out_res.summon_index;
  assign want_scythe  = out_res.want_scythe;
  assign want_mine    = out_res.want_mine;

  // The return stack never holds more entries than it has.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= DW'(STACK_DEPTH))
    else $error("return stack depth beyond its size");

  // An accepted transaction occupies the execute slot in the next cycle.
  a_accept_fills_slot: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted transaction did not reach the execute slot");

  // Executing a transaction always presents a result in the next cycle.
  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("executed transaction produced no result");

  // A halting result never carries an action request.
  a_halt_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && halt) |-> !(want_move || want_dig || want_plant || want_summon ||
                              want_scythe || want_mine))
    else $error("halt reported together with an action request");

endmodule

`default_nettype wire

/* dv/tb_routine_instruction_sequencer_core.sv */
// Self-checking testbench for the routine instruction sequencer core.
`default_nettype none

module tb_routine_instruction_sequencer_core;
  import ris_pkg::*;

  // The block is built with its default sizes, so the predictor uses the same.
  localparam int STORE_SLOTS = 256;
  localparam int STACK_SLOTS = 8;
  localparam int STIM_BYTES = 8;

  // Opcodes 13 to 15 are not defined and must halt the routine.
  localparam logic [3:0] OP_FIRST_UNDEFINED = OP_RETURN + 4'd1;

  // Random items; with the store fill and the directed steps the run sends
  // about 1900 items in all.
  localparam int RANDOM_ITEMS = 1600;
  // Upper bound on the length of the whole run, with a wide margin.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the long receiver hold-off that lets the block back up.
  localparam int HOLD_CYCLES = 150;
  // Cycles to watch for stray results once everything has drained.
  localparam int END_CYCLES = 20;

  // One input transaction as it appears on the input channel.
  typedef struct packed {
    logic       action;
    logic [7:0] load_index;
    instr_t     ins;
    logic [1:0] facing;
    logic [63:0] stimuli;
    logic       present;
  } seq_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_data = '0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  seq_item_t  drv_item = '0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       halt;
  logic       want_move;
  logic [1:0] move_rel_dir;
  logic [1:0] move_facing;
  logic       is_strafe;
  logic       want_dig;
  logic       want_plant;
  logic       want_summon;
  logic [7:0] summon_index;
  logic       want_scythe;
  logic       want_mine;

  routine_instruction_sequencer_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (drv_item.action),
    .load_index      (drv_item.load_index),
    .load_opcode     (drv_item.ins.op),
    .load_ticks      (drv_item.ins.ticks),
    .load_dir        (drv_item.ins.dir),
    .load_threshold  (drv_item.ins.threshold),
    .load_target     (drv_item.ins.target),
    .load_cond       (drv_item.ins.cond),
    .facing          (drv_item.facing),
    .stimuli_packed  (drv_item.stimuli),
    .stimuli_present (drv_item.present),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .halt            (halt),
    .want_move       (want_move),
    .move_rel_dir    (move_rel_dir),
    .move_facing     (move_facing),
    .is_strafe       (is_strafe),
    .want_dig        (want_dig),
    .want_plant      (want_plant),
    .want_summon     (want_summon),
    .summon_index    (summon_index),
    .want_scythe     (want_scythe),
    .want_mine       (want_mine)
  );

  // Free-running clock with a period of 10 time units.
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors what the block keeps: the program store, the
  // program counter, the pending wait count, the return stack and the length.
  // ---------------------------------------------------------------------------
  instr_t     program_mem [STORE_SLOTS];
  logic [8:0] routine_pc = '0;
  logic [7:0] wait_left = '0;
  logic [8:0] call_stack [STACK_SLOTS];
  int         call_depth = 0;
  logic [8:0] routine_len = '0;

  // Testbench bookkeeping.
  seq_item_t pending_items [$];
  result_t   expected_results [$];
  bit        in_pending = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;
  int        error_count = 0;
  int        results_seen = 0;
  int        cycle_count = 0;
  result_t   mon_got;
  result_t   mon_want;

  // Works out the result of one accepted transaction and advances the
  // predictor state the way one tick of the routine would.
  function automatic result_t run_tick(seq_item_t it);
    result_t     r;
    instr_t      ins;
    int unsigned eff_len;
    logic [7:0]  stim;
    r = '0;
    if (it.action == ACTION_LOAD) begin
      // A load only writes the store; the result is all zeros.
      program_mem[it.load_index] = it.ins;
      return r;
    end
    // A length above the store size behaves as the full store.
    eff_len = (routine_len > STORE_SLOTS) ? STORE_SLOTS : routine_len;
    if (eff_len == 0 || routine_pc >= eff_len) begin
      r.halt = 1'b1;
      return r;
    end
    if (wait_left != 0) begin
      wait_left = wait_left - 8'd1;
      return r;
    end
    ins = program_mem[routine_pc[7:0]];
    // The compare jumps read one stimulus byte, or zero when none are present.
    if (!it.present || ins.cond >= STIM_BYTES) stim = 8'd0;
    else stim = it.stimuli[8 * ins.cond +: 8];
    case (ins.op)
      OP_HALT: r.halt = 1'b1;
      OP_WAIT: begin
        // A wait of zero ticks acts like a wait of one.
        wait_left = (ins.ticks != 0) ? ins.ticks - 8'd1 : 8'd0;
        routine_pc = routine_pc + 9'd1;
      end
      OP_MOVE: begin
        r.want_move = 1'b1;
        r.move_rel_dir = ins.dir;
        r.move_facing = it.facing;
        r.is_strafe = (ins.threshold != 0);
        routine_pc = routine_pc + 9'd1;
      end
      OP_DIG: begin
        r.want_dig = 1'b1;
        routine_pc = routine_pc + 9'd1;
      end
      OP_PLANT: begin
        r.want_plant = 1'b1;
        routine_pc = routine_pc + 9'd1;
      end
      OP_SUMMON: begin
        r.want_summon = 1'b1;
        r.summon_index = ins.target;
        routine_pc = routine_pc + 9'd1;
      end
      OP_SCYTHE: begin
        r.want_scythe = 1'b1;
        routine_pc = routine_pc + 9'd1;
      end
      OP_MINE: begin
        r.want_mine = 1'b1;
        routine_pc = routine_pc + 9'd1;
      end
      OP_JUMP: routine_pc = {1'b0, ins.target};
      OP_JUMPIF: begin
        routine_pc = (stim > ins.threshold) ? {1'b0, ins.target} : routine_pc + 9'd1;
      end
      OP_JUMPIFNOT: begin
        routine_pc = (stim <= ins.threshold) ? {1'b0, ins.target} : routine_pc + 9'd1;
      end
      OP_CALL: begin
        // A call on a full stack halts and changes nothing.
        if (call_depth >= STACK_SLOTS) begin
          r.halt = 1'b1;
        end else begin
          call_stack[call_depth] = routine_pc + 9'd1;
          call_depth++;
          routine_pc = {1'b0, ins.target};
        end
      end
      OP_RETURN: begin
        // A return on an empty stack halts and changes nothing.
        if (call_depth == 0) begin
          r.halt = 1'b1;
        end else begin
          call_depth--;
          routine_pc = call_stack[call_depth];
        end
      end
      default: r.halt = 1'b1;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------
  // Prints one line per mismatch and counts every one of them.
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  // Monitor and acceptance tracking share one clocked block. Results are
  // compared against the oldest expectation first, then a newly accepted
  // input transaction gets its expectation appended. The cycle counter that
  // bounds the run lives here too.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) begin
        mon_got.halt = halt;
        mon_got.want_move = want_move;
        mon_got.move_rel_dir = move_rel_dir;
        mon_got.move_facing = move_facing;
        mon_got.is_strafe = is_strafe;
        mon_got.want_dig = want_dig;
        mon_got.want_plant = want_plant;
        mon_got.want_summon = want_summon;
        mon_got.summon_index = summon_index;
        mon_got.want_scythe = want_scythe;
        mon_got.want_mine = want_mine;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          mon_want = expected_results.pop_front();
          check_field("halt", mon_got.halt, mon_want.halt);
          check_field("want_move", mon_got.want_move, mon_want.want_move);
          check_field("move_rel_dir", mon_got.move_rel_dir, mon_want.move_rel_dir);
          check_field("move_facing", mon_got.move_facing, mon_want.move_facing);
          check_field("is_strafe", mon_got.is_strafe, mon_want.is_strafe);
          check_field("want_dig", mon_got.want_dig, mon_want.want_dig);
          check_field("want_plant", mon_got.want_plant, mon_want.want_plant);
          check_field("want_summon", mon_got.want_summon, mon_want.want_summon);
          check_field("summon_index", mon_got.summon_index, mon_want.summon_index);
          check_field("want_scythe", mon_got.want_scythe, mon_want.want_scythe);
          check_field("want_mine", mon_got.want_mine, mon_want.want_mine);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(run_tick(drv_item));
        in_pending = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver. On each falling edge, once the previous transaction has been
  // taken, it either presents the next queued item or leaves a gap. While a
  // transaction is offered, valid and payload are left untouched.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_pending) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_pending = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. A requested hold-off is counted down here, cycle by cycle;
  // otherwise ready stalls at random according to the current phase.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic instr_t encode_instr(logic [3:0] op, logic [7:0] target,
                                          logic [7:0] threshold, logic [2:0] cond,
                                          logic [7:0] ticks, logic [1:0] dir);
    instr_t ins;
    ins.op = op;
    ins.ticks = ticks;
    ins.dir = dir;
    ins.threshold = threshold;
    ins.target = target;
    ins.cond = cond;
    return ins;
  endfunction

  // Random instruction. Jump targets mostly land inside the routine so that
  // execution keeps going. The last slot always holds a jump, which keeps the
  // program counter from running off the end of the store. With allow_stop
  // cleared no halt or undefined opcode is produced, which is what restarts a
  // stopped routine.
  function automatic instr_t rand_instr(int unsigned len_hint, logic [7:0] slot,
                                        bit allow_stop);
    instr_t      ins;
    int unsigned r;
    do begin
      r = $urandom_range(99);
      if (r < 2) ins.op = OP_HALT;
      else if (r < 10) ins.op = OP_WAIT;
      else if (r < 22) ins.op = OP_MOVE;
      else if (r < 27) ins.op = OP_DIG;
      else if (r < 32) ins.op = OP_PLANT;
      else if (r < 37) ins.op = OP_SUMMON;
      else if (r < 42) ins.op = OP_SCYTHE;
      else if (r < 47) ins.op = OP_MINE;
      else if (r < 55) ins.op = OP_JUMP;
      else if (r < 66) ins.op = OP_JUMPIF;
      else if (r < 77) ins.op = OP_JUMPIFNOT;
      else if (r < 88) ins.op = OP_CALL;
      else if (r < 98) ins.op = OP_RETURN;
      else ins.op = OP_FIRST_UNDEFINED + 4'($urandom_range(2));
    end while (!allow_stop && (ins.op == OP_HALT || ins.op >= OP_FIRST_UNDEFINED));
    if (slot == STORE_SLOTS - 1) ins.op = OP_JUMP;
    // Waits are mostly short; a few run the full 255 ticks.
    r = $urandom_range(99);
    if (r < 70) ins.ticks = 8'($urandom_range(3));
    else if (r < 97) ins.ticks = 8'($urandom_range(255));
    else ins.ticks = 8'hFF;
    ins.dir = 2'($urandom_range(3));
    ins.threshold = ($urandom_range(99) < 25) ? 8'd0 : 8'($urandom_range(255));
    if (len_hint != 0 && $urandom_range(99) < 80)
      ins.target = 8'($urandom_range(len_hint - 1));
    else
      ins.target = 8'($urandom_range(255));
    ins.cond = 3'($urandom_range(7));
    return ins;
  endfunction

  // The fields that a load does not use still carry random values.
  function automatic seq_item_t make_load(logic [7:0] slot, instr_t ins);
    seq_item_t it;
    it.action = ACTION_LOAD;
    it.load_index = slot;
    it.ins = ins;
    it.facing = 2'($urandom_range(3));
    it.stimuli = {$urandom, $urandom};
    it.present = 1'($urandom_range(1));
    return it;
  endfunction

  // The same holds for the load fields of a step.
  function automatic seq_item_t make_step(logic [1:0] facing, logic [63:0] stimuli,
                                          logic present);
    seq_item_t   it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it.action = ACTION_STEP;
    it.load_index = 8'($urandom_range(255));
    it.ins = raw[$bits(instr_t)-1:0];
    it.facing = facing;
    it.stimuli = stimuli;
    it.present = present;
    return it;
  endfunction

  function automatic seq_item_t random_step();
    return make_step(2'($urandom_range(3)), {$urandom, $urandom},
                     $urandom_range(99) < 85);
  endfunction

  // New routine length for a phase. Usually it lies past the current program
  // counter so the routine can run; sometimes it is an extreme or arbitrary.
  function automatic logic [8:0] pick_length(logic [8:0] pc_now);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 9'd0;
    if (r < 16) return 9'(STORE_SLOTS);
    if (r < 22) return 9'h1FF;
    if (r < 27) return 9'd1;
    if (r < 40) return 9'($urandom_range(255));
    return 9'(pc_now + 1 + $urandom_range(STORE_SLOTS - 1 - pc_now));
  endfunction

  // Sender pause: returns once every queued item has been taken and every
  // expected result has come back, so the block is idle.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_pending || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Writes the routine length through the configuration channel. Only called
  // while the block is idle.
  task automatic write_length(input logic [8:0] len);
    @(negedge clk);
    cfg_data <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    routine_len = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  instr_t      tour [16];
  instr_t      ins;
  int          random_items;
  int          phase;
  int          n_items;
  int          guard;
  int unsigned eff_len;
  logic [8:0]  new_len;
  logic [7:0]  slot;

  initial begin
    // Directed routine in the first slots. It opens with a return on an empty
    // stack, then visits every action, both compare jumps, a call and return,
    // a plain jump, and ends with a call to itself that fills the stack.
    tour[0]  = encode_instr(OP_RETURN, 8'd0, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[1]  = encode_instr(OP_MOVE, 8'd0, 8'hFF, 3'd0, 8'd0, 2'd3);
    tour[2]  = encode_instr(OP_DIG, 8'd0, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[3]  = encode_instr(OP_PLANT, 8'd0, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[4]  = encode_instr(OP_SUMMON, 8'hFF, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[5]  = encode_instr(OP_SCYTHE, 8'd0, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[6]  = encode_instr(OP_MINE, 8'd0, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[7]  = encode_instr(OP_JUMPIF, 8'd9, 8'h7F, 3'd7, 8'd0, 2'd0);
    tour[8]  = encode_instr(OP_DIG, 8'd0, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[9]  = encode_instr(OP_JUMPIFNOT, 8'd11, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[10] = encode_instr(OP_PLANT, 8'd0, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[11] = encode_instr(OP_CALL, 8'd14, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[12] = encode_instr(OP_JUMP, 8'd15, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[13] = encode_instr(OP_MINE, 8'd0, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[14] = encode_instr(OP_RETURN, 8'd0, 8'd0, 3'd0, 8'd0, 2'd0);
    tour[15] = encode_instr(OP_CALL, 8'd15, 8'd0, 3'd0, 8'd0, 2'd0);

    // Synchronous reset, released on a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Right after reset the routine is empty, so a step must halt.
    pending_items.push_back(make_step(2'd0, 64'd0, 1'b1));
    // Fill the whole store, so no step can ever read a slot never written.
    for (int s = 0; s < STORE_SLOTS; s++) begin
      slot = 8'(s);
      ins = (s < 16) ? tour[s] : rand_instr(STORE_SLOTS, slot, 1'b1);
      pending_items.push_back(make_load(slot, ins));
    end
    wait_idle();
    write_length(9'd20);

    // Return on an empty stack halts; then slot 0 becomes a zero-tick wait.
    pending_items.push_back(random_step());
    pending_items.push_back(make_load(8'd0, encode_instr(OP_WAIT, 8'd0, 8'd0, 3'd0,
                                                         8'd0, 2'd0)));
    pending_items.push_back(random_step());
    // Strafe move with the largest facing, then the five other actions.
    pending_items.push_back(make_step(2'd3, 64'd0, 1'b1));
    repeat (5) pending_items.push_back(random_step());
    // The highest stimulus byte at its top value clears the threshold.
    pending_items.push_back(make_step(2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
    // With no stimuli present the byte reads as zero and the jump is taken.
    pending_items.push_back(make_step(2'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
    // Call, return, jump, then eight nested calls and an overflowing one.
    repeat (12) pending_items.push_back(random_step());
    wait_idle();

    // Random phases. Each begins from an idle block with a new length and a
    // load that puts a running instruction at the program counter, so a
    // routine stopped in the previous phase gets going again.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
      endcase
      new_len = pick_length(routine_pc);
      write_length(new_len);
      eff_len = (new_len > STORE_SLOTS) ? STORE_SLOTS : new_len;
      // Now and then the receiver holds off for a long stretch while items
      // keep coming, so the block fills up and stops taking input.
      if (phase % 8 == 5) hold_left = HOLD_CYCLES;
      pending_items.push_back(make_load(routine_pc[7:0],
                                        rand_instr(eff_len, routine_pc[7:0], 1'b0)));
      n_items = $urandom_range(40, 90);
      repeat (n_items) begin
        if ($urandom_range(99) < 15) begin
          slot = 8'($urandom_range(255));
          pending_items.push_back(make_load(slot, rand_instr(eff_len, slot, 1'b1)));
        end else begin
          pending_items.push_back(random_step());
        end
      end
      random_items += n_items + 1;
      phase++;
    end

    // Length beyond the store: with the largest length value the routine
    // runs off the last slot and must then halt at the end of the store.
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_length(9'h1FF);
    pending_items.push_back(make_load(routine_pc[7:0],
                                      encode_instr(OP_JUMP, 8'hFF, 8'd0, 3'd0, 8'd0, 2'd0)));
    pending_items.push_back(make_load(8'hFF, encode_instr(OP_DIG, 8'd0, 8'd0, 3'd0,
                                                          8'd0, 2'd0)));
    guard = 0;
    while (routine_pc != STORE_SLOTS && guard < 400) begin
      pending_items.push_back(random_step());
      wait_idle();
      guard++;
    end
    repeat (2) pending_items.push_back(random_step());

    // Drain, then watch a little longer for anything unexpected.
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
